// File: hw/rtl/bsrh_pkg.sv
// Shared types and constants for the Bayer superpixel RGB histogram block.
package bsrh_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned COUNT_BITS_DEF = 24;

  // Fixed sizes of the fields and of the histograms.
  localparam int unsigned BIN_COUNT   = 256;
  localparam int unsigned BIN_W       = 8;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned CFG_W       = 13;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned OUT_COUNT_W = 24;
  localparam int unsigned NUM_CHAN    = 3;

  // Register reset values.
  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd1936;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd1096;

  // Result queue depth.
  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_READ  = 1'b1
  } mode_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_COUNT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2,
    CH_NONE  = 2'd3
  } chan_e;

  // Item after the line store read has been issued.
  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic             emit;
    logic             clr;
    chan_e            chan;
    logic [BIN_W-1:0] bin;
    logic [PIX_W-1:0] blue;
  } stage1_t;

  // Item after the histogram reads have been issued.
  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic             emit;
    logic             clr;
    chan_e            chan;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } stage2_t;

  // One result beat as it waits in the output queue.
  typedef struct packed {
    kind_e                  kind;
    logic [PIX_W-1:0]       red;
    logic [PIX_W-1:0]       green;
    logic [PIX_W-1:0]       blue;
    logic [OUT_COUNT_W-1:0] count;
  } result_t;

endpackage

// File: hw/rtl/bayer_superpixel_rgb_histogram.sv
// Top level: Bayer RGGB superpixel reduction with three saturating RGB histograms.
//
//   channel   signals                                     handshake
//   input     mode/raw_sample/frame_start/channel/bin     in_valid_i / in_ready_o
//   output    result_kind/red/green/blue/bin_count        out_valid_o / out_ready_i
//   config    cfg_index_i / cfg_data_i                    cfg_we_i (no wait)
//
// One input beat is taken every cycle while in_ready_o is high.
// The path is line store read, histogram read, histogram update, output queue.
// in_ready_o drops only when the four-entry output queue plus items in flight is full.
// Reset clears position, registers and histogram valid bits at once; no clearing pass.
// A frame start clears all three histograms at once when it reaches the update stage.
module bayer_superpixel_rgb_histogram #(
  parameter int unsigned MAX_WIDTH  = bsrh_pkg::MAX_WIDTH_DEF,
  parameter int unsigned COUNT_BITS = bsrh_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [bsrh_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bsrh_pkg::CFG_W-1:0]        cfg_data_i,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [bsrh_pkg::SAMPLE_W-1:0]     raw_sample_i,
  input  logic                              frame_start_i,
  input  logic [1:0]                        channel_i,
  input  logic [bsrh_pkg::BIN_W-1:0]        bin_index_i,
  // Output channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              result_kind_o,
  output logic [bsrh_pkg::PIX_W-1:0]        red_o,
  output logic [bsrh_pkg::PIX_W-1:0]        green_o,
  output logic [bsrh_pkg::PIX_W-1:0]        blue_o,
  output logic [bsrh_pkg::OUT_COUNT_W-1:0]  bin_count_o
);

  localparam int unsigned CFGW        = bsrh_pkg::CFG_W;
  localparam int unsigned PW          = bsrh_pkg::PIX_W;
  localparam int unsigned BW          = bsrh_pkg::BIN_W;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);
  localparam int unsigned CLW         = $clog2(MAX_WIDTH);
  localparam int unsigned CW          = $clog2(MAX_WIDTH + 1);
  localparam int unsigned QD          = bsrh_pkg::FIFO_DEPTH;
  localparam int unsigned QPW         = $clog2(QD);
  localparam int unsigned QCW         = $clog2(QD + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers.
  logic [CFGW-1:0] frame_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= bsrh_pkg::WIDTH_RST;
      frame_height_q <= bsrh_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bsrh_pkg::CFG_WIDTH:  frame_width_q  <= cfg_data_i;
        bsrh_pkg::CFG_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: position tracking and line store access for the accepted beat.
  logic            acc, is_pixel, fs_a, emit_a, wr_red, wr_green, res_a;
  logic            row_in, col_in, row_live;
  logic [CLW-1:0]  col_q, col_cur, col_d;
  logic [CFGW-1:0] row_q, row_cur, row_d, h_even;
  logic [CW-1:0]   w_eff, w_even, col_ext, col_inc;
  logic [AW-1:0]   cell_a;
  logic [PW-1:0]   top8;

  assign acc      = in_valid_i && in_ready_o;
  assign is_pixel = (mode_i == bsrh_pkg::MODE_PIXEL);
  assign fs_a     = is_pixel && frame_start_i;
  assign top8     = raw_sample_i[bsrh_pkg::SAMPLE_W-1 -: PW];

  // Clamp the row length to the legal range.
  always_comb begin
    if (frame_width_q < CFGW'(2)) begin
      w_eff = CW'(2);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width_q);
    end
  end

  assign w_even  = {w_eff[CW-1:1], 1'b0};
  assign h_even  = {frame_height_q[CFGW-1:1], 1'b0};
  assign col_cur = frame_start_i ? '0 : col_q;
  assign row_cur = frame_start_i ? '0 : row_q;
  assign col_ext = CW'(col_cur);
  assign col_inc = col_ext + CW'(1);
  assign cell_a  = AW'(col_cur >> 1);

  assign row_in   = row_cur < h_even;
  assign col_in   = col_ext < w_even;
  assign row_live = row_cur < frame_height_q;

  // The top row of each cell goes to the store; the pixel leaves at the bottom right.
  assign wr_red   = acc && is_pixel && row_in && col_in && !row_cur[0] && !col_cur[0];
  assign wr_green = acc && is_pixel && row_in && col_in && !row_cur[0] &&  col_cur[0];
  assign emit_a   = is_pixel && row_in && col_in && row_cur[0] && col_cur[0];
  assign res_a    = !is_pixel || emit_a;

  // Next position: wrap at the row end, stop once past the frame height.
  always_comb begin
    col_d = col_cur;
    row_d = row_cur;
    if (row_live) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = row_cur + CFGW'(1);
      end else begin
        col_d = CLW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc && is_pixel) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line store, split into red and green bytes so each half is written on its own.
  logic [PW-1:0] red_store   [STORE_DEPTH];
  logic [PW-1:0] green_store [STORE_DEPTH];
  logic [PW-1:0] red_rd_q, green_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_red) begin
      red_store[cell_a] <= top8;
    end
    if (wr_green) begin
      green_store[cell_a] <= top8;
    end
    red_rd_q   <= red_store[cell_a];
    green_rd_q <= green_store[cell_a];
  end

  // ---------------------------------------------------------------------------
  // Stage B: line store data arrives, histogram reads are issued.
  bsrh_pkg::stage1_t s1_q;
  bsrh_pkg::stage2_t s2_q;
  logic              s1_res, s2_res, clr_last_q, clr_c;
  logic [PW-1:0]     pix_b [bsrh_pkg::NUM_CHAN];
  logic [COUNT_BITS-1:0] cnt_c [bsrh_pkg::NUM_CHAN];
  logic [bsrh_pkg::NUM_CHAN-1:0] we_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q       <= '0;
      s2_q       <= '0;
      clr_last_q <= 1'b0;
    end else begin
      s1_q.valid <= acc;
      s1_q.kind  <= is_pixel ? bsrh_pkg::KIND_PIXEL : bsrh_pkg::KIND_COUNT;
      s1_q.emit  <= emit_a;
      s1_q.clr   <= fs_a;
      s1_q.chan  <= bsrh_pkg::chan_e'(channel_i);
      s1_q.bin   <= bin_index_i;
      s1_q.blue  <= top8;

      s2_q.valid <= s1_q.valid;
      s2_q.kind  <= s1_q.kind;
      s2_q.emit  <= s1_q.emit;
      s2_q.clr   <= s1_q.clr;
      s2_q.chan  <= s1_q.chan;
      s2_q.red   <= red_rd_q;
      s2_q.green <= green_rd_q;
      s2_q.blue  <= s1_q.blue;

      clr_last_q <= clr_c;
    end
  end

  assign pix_b[0] = red_rd_q;
  assign pix_b[1] = green_rd_q;
  assign pix_b[2] = s1_q.blue;

  assign s1_res = s1_q.valid && (s1_q.kind == bsrh_pkg::KIND_COUNT || s1_q.emit);
  assign s2_res = s2_q.valid && (s2_q.kind == bsrh_pkg::KIND_COUNT || s2_q.emit);
  assign clr_c  = s2_q.valid && s2_q.clr;

  // ---------------------------------------------------------------------------
  // Stage C: one histogram per colour, read in B and updated here.
  for (genvar ch = 0; ch < bsrh_pkg::NUM_CHAN; ch++) begin : g_hist
    logic [COUNT_BITS-1:0]   mem [bsrh_pkg::BIN_COUNT];
    logic [bsrh_pkg::BIN_COUNT-1:0] vld_q;
    logic [BW-1:0]           addr_b, addr_q, last_wa_q;
    logic [COUNT_BITS-1:0]   rd_q, last_wd_q, cur, nxt;
    logic                    vld_rd_q, last_wv_q, hit;

    assign addr_b = (s1_q.kind == bsrh_pkg::KIND_COUNT) ? s1_q.bin : pix_b[ch];

    // The previous update has not reached the read data yet; a clear just done
    // was not seen by it either.
    assign hit = last_wv_q && (last_wa_q == addr_q);
    always_comb begin
      if (hit) begin
        cur = last_wd_q;
      end else if (clr_last_q || !vld_rd_q) begin
        cur = '0;
      end else begin
        cur = rd_q;
      end
    end

    // Saturating increment.
    assign nxt        = (&cur) ? cur : cur + COUNT_BITS'(1);
    assign we_c[ch]   = s2_q.valid && s2_q.emit;
    assign cnt_c[ch]  = cur;

    always_ff @(posedge clk_i) begin
      if (we_c[ch]) begin
        mem[addr_q] <= nxt;
      end
      rd_q   <= mem[addr_b];
      addr_q <= addr_b;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q     <= '0;
        vld_rd_q  <= 1'b0;
        last_wv_q <= 1'b0;
        last_wa_q <= '0;
        last_wd_q <= '0;
      end else begin
        vld_rd_q  <= vld_q[addr_b];
        last_wv_q <= we_c[ch];
        last_wa_q <= addr_q;
        last_wd_q <= nxt;
        if (clr_c) begin
          vld_q <= '0;
        end else if (we_c[ch]) begin
          vld_q[addr_q] <= 1'b1;
        end
      end
    end
  end

  // Build the result beat.
  bsrh_pkg::result_t push_data;
  logic [COUNT_BITS-1:0] cnt_sel;
  logic [31:0]           cnt_wide;

  always_comb begin
    case (s2_q.chan)
      bsrh_pkg::CH_RED:   cnt_sel = cnt_c[0];
      bsrh_pkg::CH_GREEN: cnt_sel = cnt_c[1];
      bsrh_pkg::CH_BLUE:  cnt_sel = cnt_c[2];
      default:            cnt_sel = '0;
    endcase
  end

  assign cnt_wide = 32'(cnt_sel);

  always_comb begin
    push_data      = '0;
    push_data.kind = s2_q.kind;
    if (s2_q.kind == bsrh_pkg::KIND_COUNT) begin
      push_data.count = cnt_wide[bsrh_pkg::OUT_COUNT_W-1:0];
    end else begin
      push_data.red   = s2_q.red;
      push_data.green = s2_q.green;
      push_data.blue  = s2_q.blue;
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue; input is held back when it could not take every beat in flight.
  bsrh_pkg::result_t fifo_q [QD];
  logic [QPW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]    fifo_cnt_q, busy;
  logic              push, pop;

  assign push       = s2_res;
  assign pop        = out_valid_o && out_ready_i;
  assign busy       = fifo_cnt_q + QCW'(s1_res) + QCW'(s2_res);
  assign in_ready_o = busy < QCW'(QD);

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QD - 1) ? '0 : wr_ptr_q + QPW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QD - 1) ? '0 : rd_ptr_q + QPW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + QCW'(push) - QCW'(pop);
    end
  end

  assign out_valid_o   = (fifo_cnt_q != '0);
  assign result_kind_o = fifo_q[rd_ptr_q].kind;
  assign red_o         = fifo_q[rd_ptr_q].red;
  assign green_o       = fifo_q[rd_ptr_q].green;
  assign blue_o        = fifo_q[rd_ptr_q].blue;
  assign bin_count_o   = fifo_q[rd_ptr_q].count;

  // ---------------------------------------------------------------------------
  // Assertions.

  // The queue plus the beats in flight never exceed the queue depth.
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy <= QCW'(QD))
    else $error("output queue credit exceeded");

  // A beat is never pushed into a full queue without one leaving.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (fifo_cnt_q < QCW'(QD)))
    else $error("output queue overflow");

  // A histogram clear never coincides with a bin update.
  a_clear_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_c |-> (we_c == '0))
    else $error("histogram clear collides with an update");

  // A frame start leaves the position on the first row.
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && fs_a) |=> (row_q == '0))
    else $error("frame start did not restart the row");

endmodule
